// ===== rtl/cnms_pkg.sv =====
// Shared types, constants and calendar helpers for the cron next-match search.
package cnms_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int WD_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int FFS_W      = 64;
   localparam int FFS_IDX_W  = 6;

   localparam int SEARCH_DAYS_DEF = 366 * 9;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEVER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MINUTE_MASK    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOUR_MASK      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MONTH_DAY_MASK = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MONTH_MASK     = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WEEK_DAY_MASK  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MONTH_DAY_RSTR = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WEEK_DAY_RSTR  = 8'd6;

   // reset values of the mask registers
   localparam logic [59:0] MINUTE_MASK_RST    = 60'h0FFF_FFFF_FFFF_FFFF;
   localparam logic [23:0] HOUR_MASK_RST      = 24'hFF_FFFF;
   localparam logic [31:0] MONTH_DAY_MASK_RST = 32'hFFFF_FFFE;
   localparam logic [12:0] MONTH_MASK_RST     = 13'h1FFE;
   localparam logic [6:0]  WEEK_DAY_MASK_RST  = 7'h7F;

   // floor(y / 100) = (y * RECIP_100) >> 19, exact for y < 43690
   localparam logic [12:0] RECIP_100 = 13'd5243;
   // floor(s / 7) = (s * RECIP_7) >> 17, exact for s < 43690
   localparam logic [14:0] RECIP_7   = 15'd18725;

   // commands from the sequencer to the calendar unit
   typedef enum logic [2:0] {
      CAL_HOLD  = 3'd0,
      CAL_LOAD  = 3'd1,
      CAL_WDSUM = 3'd2,
      CAL_WDMOD = 3'd3,
      CAL_NEXT  = 3'd4
   } cal_cmd_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [WD_W-1:0]    wd;
   } cal_date_type;

   function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
      logic [32:0] prod;
      begin
         prod = {19'd0, y} * {20'd0, RECIP_100};
         div100 = prod[26:19];
      end
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [7:0]  q;
      logic [14:0] q100;
      begin
         q = div100(y);
         q100 = {q, 6'd0} + {2'd0, q, 5'd0} + {5'd0, q, 2'd0};
         is_leap = (y[1:0] == 2'd0) &&
                   (({1'b0, y} != q100) || (q[1:0] == 2'd0));
      end
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0]  y,
                                                  input logic [MONTH_W-1:0] m);
      begin
         case (m)
            4'd2:                      month_len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
         endcase
      end
   endfunction

   // weekday offset of the first of month m (Jan/Feb counted in prior year)
   function automatic logic [WD_W-1:0] wd_offset(input logic [MONTH_W-1:0] m);
      begin
         case (m)
            4'd1:    wd_offset = 3'd0;
            4'd2:    wd_offset = 3'd3;
            4'd3:    wd_offset = 3'd2;
            4'd4:    wd_offset = 3'd5;
            4'd5:    wd_offset = 3'd0;
            4'd6:    wd_offset = 3'd3;
            4'd7:    wd_offset = 3'd5;
            4'd8:    wd_offset = 3'd1;
            4'd9:    wd_offset = 3'd4;
            4'd10:   wd_offset = 3'd6;
            4'd11:   wd_offset = 3'd2;
            4'd12:   wd_offset = 3'd4;
            default: wd_offset = 3'd0;
         endcase
      end
   endfunction

endpackage

// ===== rtl/cnms_ffs.sv =====
// Shared find-first-set unit with a lower bound, used for hour and minute.
module cnms_ffs (
   input  logic [cnms_pkg::FFS_W-1:0]     vec,
   input  logic [cnms_pkg::FFS_IDX_W-1:0] lower,
   output logic                           found,
   output logic [cnms_pkg::FFS_IDX_W-1:0] idx
);

   logic [cnms_pkg::FFS_W-1:0] masked;

   always_comb begin
      masked = vec & ({cnms_pkg::FFS_W{1'b1}} << lower);
      found  = |masked;
      idx    = '0;
      // scan high to low so the lowest set bit wins
      for (int i = cnms_pkg::FFS_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            idx = cnms_pkg::FFS_IDX_W'(i);
         end
      end
   end

endmodule

// ===== rtl/cnms_calendar.sv =====
// Calendar unit: holds the walked date, derives weekday, steps one day.
module cnms_calendar (
   input  logic                             clock,
   input  cnms_pkg::cal_cmd_type            cmd,
   input  logic [cnms_pkg::YEAR_W-1:0]      load_year,
   input  logic [cnms_pkg::MONTH_W-1:0]     load_month,
   input  logic [cnms_pkg::DAY_W-1:0]       load_day,
   output cnms_pkg::cal_date_type           date
);

   logic [cnms_pkg::YEAR_W-1:0]  year_ff,  year_in;
   logic [cnms_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cnms_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [cnms_pkg::WD_W-1:0]    wd_ff,    wd_in;
   logic [cnms_pkg::YEAR_W-1:0]  yadj_ff,  yadj_in;
   logic [7:0]                   q100_ff,  q100_in;
   logic [14:0]                  sum_ff,   sum_in;

   logic [cnms_pkg::YEAR_W-1:0]  yadj_load;
   logic [29:0]                  prod7;
   logic [12:0]                  q7;
   logic [15:0]                  q7x7;
   logic [14:0]                  rem7;

   always_comb begin
      yadj_load = (load_month < 4'd3) ? load_year - 14'd1 : load_year;
      prod7 = {15'd0, sum_ff} * {15'd0, cnms_pkg::RECIP_7};
      q7    = prod7[29:17];
      q7x7  = {q7, 3'd0} - {3'd0, q7};
      rem7  = sum_ff - q7x7[14:0];

      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      wd_in    = wd_ff;
      yadj_in  = yadj_ff;
      q100_in  = q100_ff;
      sum_in   = sum_ff;

      case (cmd)
         cnms_pkg::CAL_LOAD: begin
            year_in  = load_year;
            month_in = load_month;
            day_in   = load_day;
            yadj_in  = yadj_load;
            q100_in  = cnms_pkg::div100(yadj_load);
         end
         cnms_pkg::CAL_WDSUM: begin
            // y + y/4 - y/100 + y/400 + offset + d
            sum_in = {1'b0, yadj_ff} + {3'd0, yadj_ff[13:2]} - {7'd0, q100_ff}
                   + {9'd0, q100_ff[7:2]} + {12'd0, cnms_pkg::wd_offset(month_ff)}
                   + {10'd0, day_ff};
         end
         cnms_pkg::CAL_WDMOD: begin
            wd_in = rem7[2:0];
         end
         cnms_pkg::CAL_NEXT: begin
            wd_in = (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
            if (day_ff < cnms_pkg::month_len(year_ff, month_ff)) begin
               day_in = day_ff + 5'd1;
            end else begin
               day_in = 5'd1;
               if (month_ff < 4'd12) begin
                  month_in = month_ff + 4'd1;
               end else begin
                  month_in = 4'd1;
                  year_in  = year_ff + 14'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      wd_ff    <= wd_in;
      yadj_ff  <= yadj_in;
      q100_ff  <= q100_in;
      sum_ff   <= sum_in;
   end

   assign date = '{year: year_ff, month: month_ff, day: day_ff, wd: wd_ff};

endmodule

// ===== rtl/cron_next_match_search.sv =====
// Top level: cron next-match search with config registers and sequencer.
//
//   channel | ports                          | role
//   --------+--------------------------------+-----------------------------------
//   req     | req_valid/req_ready, req_start_* | reference minute in, one request
//   rsp     | rsp_valid/rsp_ready, rsp_*       | status and first matching minute
//   csr     | csr_valid/csr_ready, index, data | mask and flag register writes
//
// Flow: an invalid start time answers in the cycle after accept. Otherwise
//   setup runs first (weekday via two reciprocal multiplies, minute carry),
//   then the day walk: a day that fails the month/day masks is stepped in
//   S_DAY alone, and a day that passes runs the hour search, minute search
//   and a retry from the next hour. The worst case is a walk over the whole
//   day window through the shared find-first-set unit.
// Reset: synchronous; masks return to all valid positions set, flags clear.
// Stalls: req_ready is low from accept until the response is taken; the
//   response sits in an output register while rsp_ready is low. csr is
//   always ready.
module cron_next_match_search #(
   parameter int SEARCH_DAYS = cnms_pkg::SEARCH_DAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cnms_pkg::YEAR_W-1:0]         req_start_year,
   input  logic [cnms_pkg::MONTH_W-1:0]        req_start_month,
   input  logic [cnms_pkg::DAY_W-1:0]          req_start_day,
   input  logic [cnms_pkg::HOUR_W-1:0]         req_start_hour,
   input  logic [cnms_pkg::MIN_W-1:0]          req_start_min,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cnms_pkg::STATUS_W-1:0]       rsp_status,
   output logic [cnms_pkg::YEAR_W-1:0]         rsp_next_year,
   output logic [cnms_pkg::MONTH_W-1:0]        rsp_next_month,
   output logic [cnms_pkg::DAY_W-1:0]          rsp_next_day,
   output logic [cnms_pkg::HOUR_W-1:0]         rsp_next_hour,
   output logic [cnms_pkg::MIN_W-1:0]          rsp_next_min,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cnms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int OFF_W = $clog2(SEARCH_DAYS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_WDSUM = 8'b0000_0010,
      S_WDMOD = 8'b0000_0100,
      S_STEP  = 8'b0000_1000,
      S_DAY   = 8'b0001_0000,
      S_HOUR  = 8'b0010_0000,
      S_MIN   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [59:0] minute_mask_ff,    minute_mask_in;
   logic [23:0] hour_mask_ff,      hour_mask_in;
   logic [31:0] month_day_mask_ff, month_day_mask_in;
   logic [12:0] month_mask_ff,     month_mask_in;
   logic [6:0]  week_day_mask_ff,  week_day_mask_in;
   logic        md_rstr_ff,        md_rstr_in;
   logic        wd_rstr_ff,        wd_rstr_in;

   // search state
   logic [cnms_pkg::HOUR_W-1:0] sh_ff,      sh_in;
   logic [cnms_pkg::MIN_W-1:0]  sm_ff,      sm_in;
   logic [cnms_pkg::HOUR_W-1:0] hour_lb_ff, hour_lb_in;
   logic [cnms_pkg::HOUR_W-1:0] cur_hour_ff, cur_hour_in;
   logic [OFF_W-1:0]            off_ff,     off_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cnms_pkg::STATUS_W-1:0] status_ff,    status_in;
   logic [cnms_pkg::YEAR_W-1:0]   ny_ff,        ny_in;
   logic [cnms_pkg::MONTH_W-1:0]  nmo_ff,       nmo_in;
   logic [cnms_pkg::DAY_W-1:0]    nd_ff,        nd_in;
   logic [cnms_pkg::HOUR_W-1:0]   nh_ff,        nh_in;
   logic [cnms_pkg::MIN_W-1:0]    nmi_ff,       nmi_in;

   cnms_pkg::cal_cmd_type  cal_cmd;
   cnms_pkg::cal_date_type cal_date;

   logic [cnms_pkg::FFS_W-1:0]     ffs_vec;
   logic [cnms_pkg::FFS_IDX_W-1:0] ffs_lower;
   logic                           ffs_found;
   logic [cnms_pkg::FFS_IDX_W-1:0] ffs_idx;

   logic        req_fire;
   logic        start_bad;
   logic [15:0] month_mask_x;
   logic [7:0]  week_day_mask_x;
   logic        dom_hit, dow_hit, day_hit, date_hit;
   logic        first_day;
   logic        last_day;
   logic [cnms_pkg::MIN_W-1:0] min_lb;

   cnms_calendar u_calendar (
      .clock      (clock),
      .cmd        (cal_cmd),
      .load_year  (req_start_year),
      .load_month (req_start_month),
      .load_day   (req_start_day),
      .date       (cal_date)
   );

   cnms_ffs u_ffs (
      .vec   (ffs_vec),
      .lower (ffs_lower),
      .found (ffs_found),
      .idx   (ffs_idx)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // range check of the reference time straight off the ports
   assign start_bad = (req_start_year == '0) || (req_start_year > cnms_pkg::YEAR_MAX)
                   || (req_start_month == '0) || (req_start_month > 4'd12)
                   || (req_start_day == '0)
                   || (req_start_day > cnms_pkg::month_len(req_start_year, req_start_month))
                   || (req_start_hour > 5'd23) || (req_start_min > 6'd59);

   // day match: either field when both are restricted, else both
   assign month_mask_x    = {3'd0, month_mask_ff};
   assign week_day_mask_x = {1'b0, week_day_mask_ff};
   assign dom_hit  = month_day_mask_ff[cal_date.day];
   assign dow_hit  = week_day_mask_x[cal_date.wd];
   assign day_hit  = (md_rstr_ff && wd_rstr_ff) ? (dom_hit || dow_hit) : (dom_hit && dow_hit);
   assign date_hit = month_mask_x[cal_date.month] && day_hit;

   assign first_day = (off_ff == '0);
   assign last_day  = (off_ff == OFF_W'(SEARCH_DAYS));
   // minute search starts past the reference only in the reference hour
   assign min_lb    = (first_day && (cur_hour_ff == sh_ff)) ? sm_ff : '0;

   // the shared unit serves the hour mask in S_HOUR and the minute mask otherwise
   always_comb begin
      if (state_ff == S_HOUR) begin
         ffs_vec   = {40'd0, hour_mask_ff};
         ffs_lower = {1'b0, hour_lb_ff};
      end else begin
         ffs_vec   = {4'd0, minute_mask_ff};
         ffs_lower = min_lb;
      end
   end

   // configuration writes
   always_comb begin
      minute_mask_in    = minute_mask_ff;
      hour_mask_in      = hour_mask_ff;
      month_day_mask_in = month_day_mask_ff;
      month_mask_in     = month_mask_ff;
      week_day_mask_in  = week_day_mask_ff;
      md_rstr_in        = md_rstr_ff;
      wd_rstr_in        = wd_rstr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cnms_pkg::REG_MINUTE_MASK:    minute_mask_in    = csr_wdata[59:0];
            cnms_pkg::REG_HOUR_MASK:      hour_mask_in      = csr_wdata[23:0];
            cnms_pkg::REG_MONTH_DAY_MASK: month_day_mask_in = csr_wdata[31:0];
            cnms_pkg::REG_MONTH_MASK:     month_mask_in     = csr_wdata[12:0];
            cnms_pkg::REG_WEEK_DAY_MASK:  week_day_mask_in  = csr_wdata[6:0];
            cnms_pkg::REG_MONTH_DAY_RSTR: md_rstr_in        = csr_wdata[0];
            cnms_pkg::REG_WEEK_DAY_RSTR:  wd_rstr_in        = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cal_cmd      = cnms_pkg::CAL_HOLD;
      sh_in        = sh_ff;
      sm_in        = sm_ff;
      hour_lb_in   = hour_lb_ff;
      cur_hour_in  = cur_hour_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      ny_in        = ny_ff;
      nmo_in       = nmo_ff;
      nd_in        = nd_ff;
      nh_in        = nh_ff;
      nmi_in       = nmi_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sh_in  = req_start_hour;
               sm_in  = req_start_min;
               ny_in  = '0;
               nmo_in = '0;
               nd_in  = '0;
               nh_in  = '0;
               nmi_in = '0;
               if (start_bad) begin
                  status_in    = cnms_pkg::ST_RANGE;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  cal_cmd  = cnms_pkg::CAL_LOAD;
                  state_in = S_WDSUM;
               end
            end
         end
         S_WDSUM: begin
            cal_cmd  = cnms_pkg::CAL_WDSUM;
            state_in = S_WDMOD;
         end
         S_WDMOD: begin
            cal_cmd  = cnms_pkg::CAL_WDMOD;
            state_in = S_STEP;
         end
         S_STEP: begin
            // search begins at the minute after the reference
            off_in = '0;
            if (sm_ff == 6'd59) begin
               sm_in = '0;
               if (sh_ff == 5'd23) begin
                  sh_in   = '0;
                  cal_cmd = cnms_pkg::CAL_NEXT;
               end else begin
                  sh_in = sh_ff + 5'd1;
               end
            end else begin
               sm_in = sm_ff + 6'd1;
            end
            state_in = S_DAY;
         end
         S_DAY: begin
            if (cal_date.year > cnms_pkg::YEAR_MAX) begin
               status_in    = cnms_pkg::ST_RANGE;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else if (date_hit) begin
               hour_lb_in = first_day ? sh_ff : '0;
               state_in   = S_HOUR;
            end else if (last_day) begin
               status_in    = cnms_pkg::ST_NEVER;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               cal_cmd = cnms_pkg::CAL_NEXT;
               off_in  = off_ff + 1'b1;
            end
         end
         S_HOUR: begin
            if (ffs_found) begin
               cur_hour_in = ffs_idx[cnms_pkg::HOUR_W-1:0];
               state_in    = S_MIN;
            end else if (last_day) begin
               status_in    = cnms_pkg::ST_NEVER;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               cal_cmd  = cnms_pkg::CAL_NEXT;
               off_in   = off_ff + 1'b1;
               state_in = S_DAY;
            end
         end
         S_MIN: begin
            if (ffs_found) begin
               status_in    = cnms_pkg::ST_FOUND;
               ny_in        = cal_date.year;
               nmo_in       = cal_date.month;
               nd_in        = cal_date.day;
               nh_in        = cur_hour_ff;
               nmi_in       = ffs_idx;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else if ((min_lb != '0) && (cur_hour_ff != 5'd23)) begin
               // reference hour exhausted; later hours search from minute 0
               hour_lb_in = cur_hour_ff + 5'd1;
               state_in   = S_HOUR;
            end else if (last_day) begin
               status_in    = cnms_pkg::ST_NEVER;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               // an empty minute search from 0 fails every hour of the day, and after hour 23 none is left
               cal_cmd  = cnms_pkg::CAL_NEXT;
               off_in   = off_ff + 1'b1;
               state_in = S_DAY;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         minute_mask_ff    <= cnms_pkg::MINUTE_MASK_RST;
         hour_mask_ff      <= cnms_pkg::HOUR_MASK_RST;
         month_day_mask_ff <= cnms_pkg::MONTH_DAY_MASK_RST;
         month_mask_ff     <= cnms_pkg::MONTH_MASK_RST;
         week_day_mask_ff  <= cnms_pkg::WEEK_DAY_MASK_RST;
         md_rstr_ff        <= 1'b0;
         wd_rstr_ff        <= 1'b0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         minute_mask_ff    <= minute_mask_in;
         hour_mask_ff      <= hour_mask_in;
         month_day_mask_ff <= month_day_mask_in;
         month_mask_ff     <= month_mask_in;
         week_day_mask_ff  <= week_day_mask_in;
         md_rstr_ff        <= md_rstr_in;
         wd_rstr_ff        <= wd_rstr_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff       <= sh_in;
      sm_ff       <= sm_in;
      hour_lb_ff  <= hour_lb_in;
      cur_hour_ff <= cur_hour_in;
      off_ff      <= off_in;
      status_ff   <= status_in;
      ny_ff       <= ny_in;
      nmo_ff      <= nmo_in;
      nd_ff       <= nd_in;
      nh_ff       <= nh_in;
      nmi_ff      <= nmi_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_next_year  = ny_ff;
   assign rsp_next_month = nmo_ff;
   assign rsp_next_day   = nd_ff;
   assign rsp_next_hour  = nh_ff;
   assign rsp_next_min   = nmi_ff;

   // a pending response always blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a response is pending");

   // an accepted request is busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("sequencer did not leave idle after a request");

   // any miss reports an all-zero time
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != cnms_pkg::ST_FOUND)) |->
         ((rsp_next_year == '0) && (rsp_next_month == '0) && (rsp_next_day == '0)
          && (rsp_next_hour == '0) && (rsp_next_min == '0)))
      else $error("nonzero time in a miss response");

   // a found time has its hour within the hour mask
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cnms_pkg::ST_FOUND)) |->
         ((rsp_next_hour < 5'd24) && hour_mask_ff[rsp_next_hour]))
      else $error("found hour not in hour mask");

endmodule

// ===== tb/cnms_tb_pkg.sv =====
`timescale 1ns / 1ps
// Calendar predictor and expected-match tracker for the cron next-match search bench.
package cnms_tb_pkg;
   import cnms_pkg::*;

   localparam int SEARCH_WINDOW = SEARCH_DAYS_DEF;
   localparam int LAST_YEAR     = 9999;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
   } start_rec_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MIN_W-1:0]    minute;
   } match_rec_t;

   class next_match_tracker;
      logic [59:0] minute_bits;
      logic [23:0] hour_bits;
      logic [31:0] mday_bits;
      logic [12:0] month_bits;
      logic [6:0]  wday_bits;
      logic        mday_rstr;
      logic        wday_rstr;
      match_rec_t  pending_matches[$];
      int          mismatches;
      int          strays;
      int          found_n;
      int          never_n;
      int          range_n;
      int          writes;

      function new();
         minute_bits = MINUTE_MASK_RST;
         hour_bits   = HOUR_MASK_RST;
         mday_bits   = MONTH_DAY_MASK_RST;
         month_bits  = MONTH_MASK_RST;
         wday_bits   = WEEK_DAY_MASK_RST;
         mday_rstr   = 1'b0;
         wday_rstr   = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         writes++;
         case (idx)
            REG_MINUTE_MASK:    minute_bits = data[59:0];
            REG_HOUR_MASK:      hour_bits   = data[23:0];
            REG_MONTH_DAY_MASK: mday_bits   = data[31:0];
            REG_MONTH_MASK:     month_bits  = data[12:0];
            REG_WEEK_DAY_MASK:  wday_bits   = data[6:0];
            REG_MONTH_DAY_RSTR: mday_rstr   = data[0];
            REG_WEEK_DAY_RSTR:  wday_rstr   = data[0];
            default: ;
         endcase
      endfunction

      function int month_days(int y, int m);
         if (m == 2)
            return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
         if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
         return 31;
      endfunction

      // Sunday = 0; Jan and Feb count as months of the prior year
      function int weekday(int y, int m, int d);
         int base[12];
         base = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
         if (m < 3)
            y = y - 1;
         return (y + y / 4 - y / 100 + y / 400 + base[m-1] + d) % 7;
      endfunction

      function void advance(inout int y, inout int m, inout int d, inout int wd);
         wd = (wd + 1) % 7;
         if (d < month_days(y, m)) begin
            d++;
         end else begin
            d = 1;
            if (m < 12) begin
               m++;
            end else begin
               m = 1;
               y++;
            end
         end
      endfunction

      // either day field may match only when both are restricted
      function bit day_hit(int d, int wd);
         bit dom;
         bit dow;
         dom = mday_bits[d];
         dow = wday_bits[wd];
         if (mday_rstr && wday_rstr)
            return dom || dow;
         return dom && dow;
      endfunction

      function match_rec_t search(start_rec_t s);
         match_rec_t r;
         int y, m, d, sh, sm, wd, h, mi, off;
         r = '0;
         y  = s.year;
         m  = s.month;
         d  = s.day;
         sh = s.hour;
         sm = s.minute;
         if (y < 1 || y > LAST_YEAR || m < 1 || m > 12 || d < 1 ||
             d > month_days(y, m) || sh > 23 || sm > 59) begin
            r.status = ST_RANGE;
            return r;
         end
         wd = weekday(y, m, d);
         sm++;
         if (sm == 60) begin
            sm = 0;
            sh++;
            if (sh == 24) begin
               sh = 0;
               advance(y, m, d, wd);
            end
         end
         for (off = 0; off <= SEARCH_WINDOW; off++) begin
            if (y > LAST_YEAR) begin
               r.status = ST_RANGE;
               return r;
            end
            if (month_bits[m] && day_hit(d, wd)) begin
               for (h = (off == 0) ? sh : 0; h < 24; h++) begin
                  if (!hour_bits[h])
                     continue;
                  for (mi = (off == 0 && h == sh) ? sm : 0; mi < 60; mi++) begin
                     if (minute_bits[mi]) begin
                        r.status = ST_FOUND;
                        r.year   = y;
                        r.month  = m;
                        r.day    = d;
                        r.hour   = h;
                        r.minute = mi;
                        return r;
                     end
                  end
               end
            end
            advance(y, m, d, wd);
         end
         r.status = ST_NEVER;
         return r;
      endfunction

      function void note_start(start_rec_t s);
         match_rec_t r;
         r = search(s);
         case (r.status)
            ST_FOUND: found_n++;
            ST_NEVER: never_n++;
            default:  range_n++;
         endcase
         pending_matches.push_back(r);
      endfunction

      function bit same(string label, int e, int g);
         if (e == g)
            return 1'b1;
         $display("%0t: %s expected %0d, got %0d", $time, label, e, g);
         return 1'b0;
      endfunction

      function void check_match(match_rec_t got);
         match_rec_t e;
         bit ok;
         if (pending_matches.size() == 0) begin
            strays++;
            $display("%0t: response with nothing outstanding, status %0d", $time, got.status);
            return;
         end
         e = pending_matches.pop_front();
         ok = same("status", e.status, got.status) &
              same("next_year", e.year, got.year) &
              same("next_month", e.month, got.month) &
              same("next_day", e.day, got.day) &
              same("next_hour", e.hour, got.hour) &
              same("next_min", e.minute, got.minute);
         if (!ok)
            mismatches++;
      endfunction

      function int pending();
         return pending_matches.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level bench for cron_next_match_search: stimulus, handshakes and checking.
module tb_top;
   import cnms_pkg::*;
   import cnms_tb_pkg::*;

   localparam int IDLE_PCT       = 35;     // chance per cycle that a side idles
   localparam int WATCHDOG_LIMIT = 40000;  // well above the slowest search plus the long hold
   localparam int HOLD_CYCLES    = 600;    // long rsp hold-off
   localparam int HOLD_AT        = 80;     // responses seen before the hold starts
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 22;

   // indexes with no register behind them; writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_FIRST = 8'd7;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LAST  = 8'd255;

   localparam logic [CSR_DATA_W-1:0] ALL_ONES = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [YEAR_W-1:0]      req_start_year  = '0;
   logic [MONTH_W-1:0]     req_start_month = '0;
   logic [DAY_W-1:0]       req_start_day   = '0;
   logic [HOUR_W-1:0]      req_start_hour  = '0;
   logic [MIN_W-1:0]       req_start_min   = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [YEAR_W-1:0]      rsp_next_year;
   logic [MONTH_W-1:0]     rsp_next_month;
   logic [DAY_W-1:0]       rsp_next_day;
   logic [HOUR_W-1:0]      rsp_next_hour;
   logic [MIN_W-1:0]       rsp_next_min;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   next_match_tracker tracker;
   bit         quiet     = 1'b0;   // no idling on either side while set
   bit         hold_done = 1'b0;
   int         hold_left = 0;
   int         rsp_seen  = 0;
   int         settings  = 0;
   start_rec_t seen_start;
   match_rec_t seen_match;

   always #6 clock = ~clock;

   cron_next_match_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_start_hour  (req_start_hour),
      .req_start_min   (req_start_min),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_next_year   (rsp_next_year),
      .rsp_next_month  (rsp_next_month),
      .rsp_next_day    (rsp_next_day),
      .rsp_next_hour   (rsp_next_hour),
      .rsp_next_min    (rsp_next_min),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge. Register writes go
   // to the predictor's copy first; a response is checked before a request
   // accepted on the same edge is queued (it can only belong to an older one).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.write_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            seen_match = '{rsp_status, rsp_next_year, rsp_next_month,
                           rsp_next_day, rsp_next_hour, rsp_next_min};
            tracker.check_match(seen_match);
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            seen_start = '{req_start_year, req_start_month, req_start_day,
                           req_start_hour, req_start_min};
            tracker.note_start(seen_start);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, one long hold-off once enough
   // responses have gone by. The hold is counted here so the sender keeps
   // offering its next request and the block backs up into req_ready.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!hold_done && rsp_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any handshake resets the count. The limit sits above a single
   // search through the whole window plus the long response hold-off.
   // ---------------------------------------------------------------------
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no handshake for %0d cycles, %0d requests outstanding",
               $time, WATCHDOG_LIMIT, tracker.pending());
      $display("Regression FAIL");
      $finish;
   end

   // One request. Entered and left at a falling edge; valid stays high on
   // return so back-to-back requests need no gap.
   task automatic push_start(int y, int m, int d, int h, int mi);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_start_year  <= y[YEAR_W-1:0];
      req_start_month <= m[MONTH_W-1:0];
      req_start_day   <= d[DAY_W-1:0];
      req_start_hour  <= h[HOUR_W-1:0];
      req_start_min   <= mi[MIN_W-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // csr_valid is left high; program_masks drops it after the last write
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_masks(logic [CSR_DATA_W-1:0] mn, logic [CSR_DATA_W-1:0] hr,
                                logic [CSR_DATA_W-1:0] md, logic [CSR_DATA_W-1:0] mo,
                                logic [CSR_DATA_W-1:0] wk, logic [CSR_DATA_W-1:0] mdr,
                                logic [CSR_DATA_W-1:0] wdr, bit spare);
      write_reg(REG_MINUTE_MASK, mn);
      write_reg(REG_HOUR_MASK, hr);
      write_reg(REG_MONTH_DAY_MASK, md);
      write_reg(REG_MONTH_MASK, mo);
      write_reg(REG_WEEK_DAY_MASK, wk);
      write_reg(REG_MONTH_DAY_RSTR, mdr);
      write_reg(REG_WEEK_DAY_RSTR, wdr);
      if (spare) begin
         write_reg(REG_SPARE_FIRST, {$urandom, $urandom});
         write_reg(REG_SPARE_LAST, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   // full hour mask and no spare writes: every other field is the caller's
   task automatic program_full_except(logic [CSR_DATA_W-1:0] mn, logic [CSR_DATA_W-1:0] md,
                                      logic [CSR_DATA_W-1:0] mo, logic [CSR_DATA_W-1:0] wk,
                                      logic [CSR_DATA_W-1:0] mdr,
                                      logic [CSR_DATA_W-1:0] wdr);
      program_masks(mn, HOUR_MASK_RST, md, mo, wk, mdr, wdr, 1'b0);
   endtask

   // masks may only change with nothing in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // random junk above a register's width; the block must drop it
   function automatic logic [CSR_DATA_W-1:0] above(int w);
      return {$urandom, $urandom} << w;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] one_bit(int lo, int hi, int w);
      return (64'd1 << $urandom_range(hi, lo)) | above(w);
   endfunction

   // dense: every bit a coin flip; sparse: one usable bit per mask, so the walk
   // runs long (up to years) and sometimes never meets a match
   task automatic random_masks(bit sparse);
      if (sparse)
         program_masks(one_bit(0, 59, 60), one_bit(0, 23, 24),
                       one_bit(1, 31, 32) | $urandom_range(1),
                       one_bit(1, 12, 13) | $urandom_range(1),
                       one_bit(0, 6, 7), {$urandom, $urandom}, {$urandom, $urandom},
                       $urandom_range(1));
      else
         program_masks({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, $urandom_range(1));
   endtask

   // mostly valid times with edge years and day/month carries; a few raw
   // bit patterns, which are mostly rejected as invalid
   task automatic push_random();
      int y, m, d, h, mi, pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         y  = $urandom_range(16383);
         m  = $urandom_range(15);
         d  = $urandom_range(31);
         h  = $urandom_range(31);
         mi = $urandom_range(63);
      end else begin
         case ($urandom_range(5))
            0:       y = $urandom_range(9999, 9990);
            1:       y = $urandom_range(10, 1);
            default: y = $urandom_range(9999, 1);
         endcase
         m  = $urandom_range(12, 1);
         d  = $urandom_range(tracker.month_days(y, m), 1);
         h  = $urandom_range(23);
         mi = $urandom_range(59);
         if (pick < 25) begin
            h  = 23;
            mi = 59;
            if (pick < 16)
               d = tracker.month_days(y, m);
         end
      end
      push_start(y, m, d, h, mi);
   endtask

   initial begin
      bit failed;
      tracker = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- reset masks: field extremes, carries and invalid times ---
      push_start(1, 1, 1, 0, 0);
      push_start(9999, 12, 31, 23, 59);     // carry lands in year 10000
      push_start(9999, 12, 31, 23, 58);
      push_start(2023, 12, 31, 23, 59);     // year carry
      push_start(2024, 2, 28, 23, 59);      // into leap day
      push_start(2023, 2, 28, 23, 59);      // no leap day
      push_start(2000, 2, 29, 12, 30);      // leap by the 400 rule
      push_start(1900, 2, 29, 0, 0);        // not leap by the 100 rule
      push_start(0, 6, 1, 0, 0);
      push_start(10000, 6, 1, 0, 0);
      push_start(16383, 15, 31, 31, 63);    // every input bit high
      push_start(2021, 0, 10, 0, 0);
      push_start(2021, 13, 10, 0, 0);
      push_start(2021, 5, 0, 0, 0);
      push_start(2021, 4, 31, 0, 0);        // day past month end
      push_start(2021, 5, 5, 24, 0);
      push_start(2021, 5, 5, 10, 60);
      push_start(2021, 6, 15, 0, 59);       // hour carry
      push_start(2021, 6, 30, 23, 59);      // month carry
      drain();

      // --- Feb 29 12:30 only: walks across the century gaps in leap years ---
      program_masks(64'd1 << 30, 64'd1 << 12, 64'd1 << 29, 64'd1 << 2,
                    WEEK_DAY_MASK_RST, 64'd0, 64'd0, 1'b0);
      push_start(2096, 3, 1, 0, 0);
      push_start(1896, 3, 1, 0, 0);
      push_start(2024, 2, 29, 12, 30);      // strictly later: next leap year
      push_start(2024, 2, 29, 12, 29);
      push_start(9997, 3, 1, 0, 0);         // runs out of years first
      drain();

      // --- 13th or Friday: both day fields restricted, either matches ---
      program_full_except(MINUTE_MASK_RST, 64'd1 << 13, MONTH_MASK_RST, 64'd1 << 5,
                          64'd1, 64'd1);
      push_start(2023, 1, 12, 23, 59);
      push_start(2023, 1, 5, 23, 59);
      push_random();
      push_random();
      drain();

      // --- 13th and Friday: only day of month restricted, both must match ---
      program_full_except(MINUTE_MASK_RST, 64'd1 << 13, MONTH_MASK_RST, 64'd1 << 5,
                          64'd1, 64'd0);
      push_start(2023, 1, 14, 0, 0);
      push_random();
      push_random();
      drain();

      // --- empty minute mask: every day passes but no minute does ---
      program_full_except(64'd0, MONTH_DAY_MASK_RST, MONTH_MASK_RST, WEEK_DAY_MASK_RST,
                          64'd0, 64'd0);
      push_start(2023, 5, 5, 10, 10);
      push_start(9995, 1, 1, 0, 0);
      drain();

      // --- only the unused bit 0 set in the day-of-month mask, then in the month mask ---
      program_full_except(MINUTE_MASK_RST, 64'd1, MONTH_MASK_RST, 64'd0, 64'd1, 64'd1);
      push_start(2022, 7, 7, 7, 7);
      drain();
      program_full_except(MINUTE_MASK_RST, MONTH_DAY_MASK_RST, 64'd1, WEEK_DAY_MASK_RST,
                          64'd0, 64'd0);
      push_start(2022, 7, 7, 7, 7);
      drain();

      // --- register extremes: all zero, then all ones plus spare indexes ---
      program_masks(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      push_start(2010, 10, 10, 10, 10);
      drain();
      program_masks(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                    1'b1);
      push_start(2020, 2, 29, 23, 59);
      push_start(9999, 12, 31, 23, 59);
      push_random();
      drain();

      // --- random masks and requests; the third phase runs without idling ---
      for (int phase = 0; phase < 6; phase++) begin
         random_masks(phase % 2 == 1);
         quiet = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++)
            push_random();
         drain();
         quiet = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Searched %0d start times: %0d matched, %0d never matched, %0d out of range",
               tracker.found_n + tracker.never_n + tracker.range_n, tracker.found_n,
               tracker.never_n, tracker.range_n);
      $display("%0d register writes across %0d mask settings, one %0d-cycle response hold",
               tracker.writes, settings, HOLD_CYCLES);
      failed = (tracker.mismatches != 0) || (tracker.strays != 0) ||
               (tracker.pending() != 0);
      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("%0d bad responses, %0d unexpected, %0d missing",
                  tracker.mismatches, tracker.strays, tracker.pending());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
